/* hw/rtl/sks_pkg.sv */
// Package for the sorted key set engine: sizes, opcodes, status codes,
// beat structs and controller states. No dependencies.
package sks_pkg;
  localparam int Capacity = 64;
  localparam int KeyBits = 32;
  localparam int IdxW = $clog2(Capacity);
  localparam int CntW = $clog2(Capacity + 1);

  typedef enum logic [3:0] {
    OP_INSERT = 4'd0, OP_REMOVE = 4'd1, OP_EXISTS = 4'd2, OP_MIN = 4'd3,
    OP_MAX = 4'd4, OP_POP_MIN = 4'd5, OP_POP_MAX = 4'd6, OP_PRED = 4'd7,
    OP_POP_PRED = 4'd8, OP_SUCC = 4'd9, OP_POP_SUCC = 4'd10, OP_CLEAR = 4'd11
  } sks_op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_DUP_ABSENT = 2'd1, ST_EMPTY = 2'd2, ST_FULL = 2'd3
  } sks_status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_DECIDE, S_INS_RD, S_INS_WR, S_DEL_RD, S_DEL_WR, S_DONE
  } sks_state_t;

  typedef struct packed {
    logic [3:0] opcode;
    logic [KeyBits-1:0] key;
  } sks_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [KeyBits-1:0] value;
    logic [CntW-1:0] count;
  } sks_out_t;
endpackage

/* hw/rtl/sorted_key_set_engine.sv */
// Sorted key set engine top level: key memory, binary search and shift sequencer.
// Depends on sks_pkg.
//
// channel | dir | beat
// in_     | in  | sks_in_t  (opcode, key)
// out_    | out | sks_out_t (status, value, count)
//
// One item at a time. Clear and unused opcodes finish in S_IDLE; min/max read through S_DONE.
// A search steps through S_SEARCH and S_DECIDE per probe (up to log2(depth)+1 probes), then
// a final read; insert/remove then shift the tail through the single write port,
// reading and then writing each moved entry.
// Reset empties the set at once; memory contents are not cleared.
// A waiting result stalls the next item until out_ready.
module sorted_key_set_engine import sks_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  sks_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output sks_out_t out_data
);
  logic [KeyBits-1:0] mem [Capacity];
  logic [KeyBits-1:0] rd_q;

  sks_state_t state_r, state_nxt;
  logic [3:0] op_r;
  logic [KeyBits-1:0] key_r;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [CntW-1:0] lo_r, hi_r, lo_nxt, hi_nxt;
  logic [CntW-1:0] ptr_r, ptr_nxt;
  logic [CntW-1:0] mid_r, mid_nxt;
  logic out_valid_r, out_valid_nxt;
  sks_out_t out_r;

  logic rd_en, wr_en;
  logic [IdxW-1:0] rd_addr, wr_addr;
  logic [KeyBits-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  logic upper_op;
  assign upper_op = (op_r == OP_SUCC) || (op_r == OP_POP_SUCC);
  assign in_ready = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  // decide-stage helpers on lower/upper bound p = lo_r
  logic hit, p_lt_cnt;
  assign p_lt_cnt = lo_r < cnt_r;
  assign hit = p_lt_cnt && (rd_q == key_r);

  always_comb begin
    cnt_nxt = cnt_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    ptr_nxt = ptr_r;
    mid_nxt = mid_r;
    out_valid_nxt = out_valid_r;
    rd_en = 1'b0;
    rd_addr = '0;
    wr_en = 1'b0;
    wr_addr = '0;
    wr_data = key_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        lo_nxt = '0;
        hi_nxt = cnt_r;
      end
      S_SEARCH: begin
        // issue a probe, or a read of position lo when the range is closed
        if (lo_r < hi_r) begin
          mid_nxt = lo_r + ((hi_r - lo_r) >> 1);
          rd_en = 1'b1;
          rd_addr = mid_nxt[IdxW-1:0];
        end else begin
          rd_en = 1'b1;
          rd_addr = lo_r[IdxW-1:0];
        end
      end
      S_DECIDE: begin
        if (lo_r < hi_r) begin
          if (upper_op ? (rd_q <= key_r) : (rd_q < key_r)) lo_nxt = mid_r + 1'b1;
          else hi_nxt = mid_r;
        end
      end
      S_INS_RD: begin
        rd_en = 1'b1;
        rd_addr = IdxW'(ptr_r - 1'b1);
      end
      S_INS_WR: begin
        wr_en = 1'b1;
        wr_addr = ptr_r[IdxW-1:0];
        if (ptr_r == lo_r) wr_data = key_r;
        else begin
          wr_data = rd_q;
          ptr_nxt = ptr_r - 1'b1;
        end
      end
      S_DEL_RD: begin
        rd_en = 1'b1;
        rd_addr = IdxW'(ptr_r + 1'b1);
      end
      S_DEL_WR: begin
        wr_en = 1'b1;
        wr_addr = ptr_r[IdxW-1:0];
        wr_data = rd_q;
        ptr_nxt = ptr_r + 1'b1;
      end
      default: ;
    endcase
  end

  // prefetched entry for S_DONE, read on the cycle before it
  logic [KeyBits-1:0] mem_pre_q;

  // sequencer: transitions and result formation
  logic [CntW-1:0] cnt_seq, ptr_seq, lo_seq;
  logic ov_set;
  sks_out_t res;
  always_comb begin
    state_nxt = state_r;
    cnt_seq = cnt_nxt;
    ptr_seq = ptr_nxt;
    lo_seq = lo_nxt;
    ov_set = 1'b0;
    res = '0;
    unique case (state_r)
      S_IDLE: if (in_valid && in_ready) begin
        state_nxt = S_SEARCH;
        if (in_data.opcode == OP_CLEAR || in_data.opcode > OP_CLEAR) begin
          if (in_data.opcode == OP_CLEAR) cnt_seq = '0;
          res.status = ST_OK;
          res.count = CntW'(in_data.opcode == OP_CLEAR ? '0 : cnt_r);
          ov_set = 1'b1;
          state_nxt = S_IDLE;
        end else if (in_data.opcode >= OP_MIN && in_data.opcode <= OP_POP_MAX) begin
          state_nxt = S_DONE;
        end
      end
      S_SEARCH: state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (lo_r < hi_r) state_nxt = S_SEARCH;
        else begin
          state_nxt = S_IDLE;
          ov_set = 1'b1;
          res.count = cnt_r;
          unique case (op_r)
            OP_INSERT: begin
              if (hit) res.status = ST_DUP_ABSENT;
              else if (cnt_r >= CntW'(Capacity)) res.status = ST_FULL;
              else begin
                res.value = key_r;
                res.count = CntW'(cnt_r + 1'b1);
                cnt_seq = cnt_r + 1'b1;
                ptr_seq = cnt_r;
                state_nxt = S_INS_WR;
                if (cnt_r != lo_r) state_nxt = S_INS_RD;
              end
            end
            OP_REMOVE, OP_EXISTS: begin
              if (!hit) res.status = ST_DUP_ABSENT;
              else begin
                res.value = key_r;
                if (op_r == OP_REMOVE) begin
                  res.count = CntW'(cnt_r - 1'b1);
                  cnt_seq = cnt_r - 1'b1;
                  ptr_seq = lo_r;
                  if (CntW'(lo_r + 1'b1) < cnt_r) state_nxt = S_DEL_RD;
                end
              end
            end
            OP_SUCC, OP_POP_SUCC: begin
              if (!p_lt_cnt) res.status = ST_EMPTY;
              else begin
                res.value = rd_q;
                if (op_r == OP_POP_SUCC) begin
                  res.count = CntW'(cnt_r - 1'b1);
                  cnt_seq = cnt_r - 1'b1;
                  ptr_seq = lo_r;
                  if (CntW'(lo_r + 1'b1) < cnt_r) state_nxt = S_DEL_RD;
                end
              end
            end
            OP_PRED, OP_POP_PRED: begin
              // predecessor is at lo-1: reread it
              if (lo_r == '0) res.status = ST_EMPTY;
              else begin
                ov_set = 1'b0;
                lo_seq = lo_r - 1'b1;
                state_nxt = S_DONE;
              end
            end
            default: ;
          endcase
        end
      end
      S_INS_RD: state_nxt = S_INS_WR;
      S_INS_WR: state_nxt = (ptr_r == lo_r) ? S_IDLE
                         : ((ptr_nxt == lo_r) ? S_INS_WR : S_INS_RD);
      S_DEL_RD: state_nxt = S_DEL_WR;
      S_DEL_WR: state_nxt = (CntW'(ptr_r + 2'd2) < CntW'(cnt_r + 1'b1)) ? S_DEL_RD : S_IDLE;
      S_DONE: begin
        state_nxt = S_IDLE;
        ov_set = 1'b1;
        res.count = cnt_r;
        if (op_r == OP_PRED || op_r == OP_POP_PRED) begin
          res.value = mem_pre_q;
          if (op_r == OP_POP_PRED) begin
            res.count = CntW'(cnt_r - 1'b1);
            cnt_seq = cnt_r - 1'b1;
            ptr_seq = lo_r;
            if (CntW'(lo_r + 1'b1) < cnt_r) state_nxt = S_DEL_RD;
          end
        end else if (cnt_r == '0) res.status = ST_EMPTY;
        else begin
          res.value = mem_pre_q;
          if (op_r == OP_POP_MIN || op_r == OP_POP_MAX) begin
            res.count = CntW'(cnt_r - 1'b1);
            cnt_seq = cnt_r - 1'b1;
            ptr_seq = '0;
            if (op_r == OP_POP_MIN && cnt_r > CntW'(1)) state_nxt = S_DEL_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  logic [IdxW-1:0] pre_addr;
  always_comb begin
    pre_addr = lo_seq[IdxW-1:0];
    if (state_r == S_IDLE)
      pre_addr = (in_data.opcode == OP_MIN || in_data.opcode == OP_POP_MIN || cnt_r == '0)
                 ? '0 : IdxW'(cnt_r - 1'b1);
  end
  always_ff @(posedge clk) begin
    if (state_nxt == S_DONE && state_r != S_DONE) mem_pre_q <= mem[pre_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_seq;
      out_valid_r <= ov_set ? 1'b1 : out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid && in_ready) begin
      op_r <= in_data.opcode;
      key_r <= in_data.key;
    end
    lo_r <= lo_seq;
    hi_r <= hi_nxt;
    ptr_r <= ptr_seq;
    mid_r <= mid_nxt;
    if (ov_set) out_r <= res;
  end
endmodule

/* hw/rtl/sks_checker.sv */
// Port-level checker for the sorted key set engine, bound to the top level.
// Depends on sks_pkg.
module sks_checker import sks_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input sks_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input sks_out_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out beat dropped");
  a_zero_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.value == '0) else $error("value not zero");
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.count <= CntW'(Capacity)) else $error("count over capacity");
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("second item taken");
endmodule

bind sorted_key_set_engine sks_checker u_sks_checker (.*);
